// ===== sv/sorted_timer_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted timer queue
// Short forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMER_QUEUE_TOP_ASSERT_SVH
`define SORTED_TIMER_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define STQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define STQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== sv/stq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Types, sizes and codes shared by the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ID_W   = 8;
    localparam int TIME_W = 40;
    localparam int EL_W   = 39;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_FIRE   = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_CMP,
        ST_SHIFT,
        ST_DONE
    } t_state;

    // per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        CO_HOLD,
        CO_POP,
        CO_CMP_INS,
        CO_CMP_REM,
        CO_SHIFT_INS,
        CO_SHIFT_REM
    } t_cell_op;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [TIME_W-1:0] time_v;
    } t_entry;

    typedef struct packed {
        t_cell_op                 op;
        t_entry                   key;
        logic [EL_W-1:0]          elapsed;
    } t_cell_bus;

    typedef struct packed {
        logic [1:0]               req_type;
        logic [ID_W-1:0]          timer_id;
        logic signed [TIME_W-1:0] time_value;
        logic [EL_W-1:0]          elapsed;
        logic                     rearm;
    } t_req;

    typedef struct packed {
        t_status                  status;
        logic [ID_W-1:0]          fired_id;
        logic                     head_valid;
        logic [ID_W-1:0]          head_id;
        logic signed [TIME_W-1:0] head_time;
        logic [CNT_W-1:0]         timer_count;
    } t_rsp;

    function automatic logic t_less(input logic signed [TIME_W-1:0] a,
                                    input logic signed [TIME_W-1:0] b);
        return a < b;
    endfunction

endpackage

// ===== sv/stq_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_req_if / stq_rsp_if
// Valid/ready channels carrying timer requests and results.
// ----------------------------------------------------------------------------
interface stq_req_if;
    import stq_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stq_rsp_if;
    import stq_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sorted_timer_queue_top.sv =====
`timescale 1ns / 1ps
// From request transfer to result register: an ignored or rejected request
// goes straight to the done state, a fire without rearm passes the pop state,
// insert and remove pass compare and shift, and a fire with rearm passes pop,
// compare and shift. One request is in work at a time; the next transfer is
// taken the cycle after the result is registered, once the output register is free.
// Reset (synchronous, active low) empties the queue and the result register.
// ----------------------------------------------------------------------------
// sorted_timer_queue_top
// Timer list kept sorted by remaining time in a chain of compare/shift cells.
// ----------------------------------------------------------------------------
module sorted_timer_queue_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    stq_req_if.sink        i_req,
    stq_rsp_if.source      o_rsp
);
    import stq_pkg::*;

    // control
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ins, n_ins;        // pending compare is an insert
    t_status             r_status, n_status;
    logic [ID_W-1:0]     r_fired, n_fired;
    logic                r_rsp_valid, n_rsp_valid;

    // captured request payload
    t_entry              r_key, n_key;
    logic [EL_W-1:0]     r_el, n_el;
    logic                r_rearm, n_rearm;

    t_rsp                r_rsp, n_rsp;

    // cell chain wiring
    t_cell_bus           w_bus;
    t_entry              w_entry [DEPTH];
    logic                w_any   [DEPTH+1];

    logic                w_take;              // request transfer this cycle
    logic                w_found;             // some cell flagged in the compare pass

    assign w_take  = i_req.valid && i_req.ready;
    assign w_found = w_any[DEPTH];
    assign w_any[0] = 1'b0;

    genvar k;
    generate
        for (k = 0; k < DEPTH; k++) begin : g_cell
            t_entry w_left, w_right;
            logic   w_occ;
            if (k == 0) begin : g_first
                assign w_left = r_key;
            end else begin : g_mid_l
                assign w_left = w_entry[k-1];
            end
            if (k == DEPTH - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_entry[k+1];
            end
            assign w_occ = r_count > CNT_W'(k);

            stq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_bus     (w_bus),
                .i_is_head (k == 0),
                .i_occ     (w_occ),
                .i_left    (w_left),
                .i_right   (w_right),
                .i_any     (w_any[k]),
                .o_any     (w_any[k+1]),
                .o_entry   (w_entry[k])
            );
        end
    endgenerate

    // sequencer: next state, cell command and result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ins       = r_ins;
        n_status    = r_status;
        n_fired     = r_fired;
        n_key       = r_key;
        n_el        = r_el;
        n_rearm     = r_rearm;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        w_bus.op      = CO_HOLD;
        w_bus.key     = r_key;
        w_bus.elapsed = r_el;

        // result drained by the sink
        if (o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_key.id     = i_req.data.timer_id;
                    n_key.time_v = i_req.data.time_value;
                    n_el         = i_req.data.elapsed;
                    n_rearm      = i_req.data.rearm;
                    n_status     = STAT_OK;
                    n_fired      = '0;
                    case (t_req_type'(i_req.data.req_type))
                        REQ_INSERT: begin
                            n_ins = 1'b1;
                            if (r_count == CNT_W'(DEPTH)) begin
                                n_status = STAT_FULL;
                                n_state  = ST_DONE;
                            end else begin
                                n_state = ST_CMP;
                            end
                        end
                        REQ_REMOVE: begin
                            n_ins   = 1'b0;
                            n_state = ST_CMP;
                        end
                        REQ_FIRE: begin
                            n_ins = 1'b1;
                            if (r_count == '0) begin
                                n_status = STAT_EMPTY;
                                n_state  = ST_DONE;
                            end else begin
                                n_fired = w_entry[0].id;
                                n_state = ST_POP;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_POP: begin
                // drop head, age the rest; rearm re-inserts the popped id
                w_bus.op = CO_POP;
                n_count  = r_count - CNT_W'(1);
                n_key.id = r_fired;
                n_state  = r_rearm ? ST_CMP : ST_DONE;
            end
            ST_CMP: begin
                w_bus.op = r_ins ? CO_CMP_INS : CO_CMP_REM;
                n_state  = ST_SHIFT;
            end
            ST_SHIFT: begin
                w_bus.op = r_ins ? CO_SHIFT_INS : CO_SHIFT_REM;
                if (r_ins) begin
                    n_count = r_count + CNT_W'(1);
                end else if (w_found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = STAT_NOT_FOUND;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // load result once the output register is free
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp.status      = r_status;
                    n_rsp.fired_id    = r_fired;
                    n_rsp.head_valid  = r_count != '0;
                    n_rsp.head_id     = (r_count != '0) ? w_entry[0].id : '0;
                    n_rsp.head_time   = (r_count != '0) ? w_entry[0].time_v : '0;
                    n_rsp.timer_count = r_count;
                    n_rsp_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ins       <= 1'b0;
            r_status    <= STAT_OK;
            r_fired     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ins       <= n_ins;
            r_status    <= n_status;
            r_fired     <= n_fired;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_el    <= n_el;
        r_rearm <= n_rearm;
        r_rsp   <= n_rsp;
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

endmodule

// ===== sv/stq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the timer chain: compare, shift and pop against its neighbors.
// ----------------------------------------------------------------------------
module stq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stq_pkg::t_cell_bus i_bus,
    input  logic               i_is_head,
    input  logic               i_occ,
    input  stq_pkg::t_entry    i_left,
    input  stq_pkg::t_entry    i_right,
    input  logic               i_any,
    output logic               o_any,
    output stq_pkg::t_entry    o_entry
);
    import stq_pkg::*;

    t_entry r_entry, n_entry;
    logic   r_flag, n_flag;

    always_comb begin
        n_entry = r_entry;
        n_flag  = r_flag;
        case (i_bus.op)
            CO_POP: begin
                n_entry.id     = i_right.id;
                n_entry.time_v = i_right.time_v - $signed({1'b0, i_bus.elapsed});
            end
            CO_CMP_INS: begin
                // head: go first only if head is strictly later
                if (i_is_head) begin
                    n_flag = !i_occ || t_less(i_bus.key.time_v, r_entry.time_v);
                end else begin
                    n_flag = !i_occ || !t_less(r_entry.time_v, i_bus.key.time_v);
                end
            end
            CO_CMP_REM: n_flag = i_occ && (r_entry.id == i_bus.key.id);
            CO_SHIFT_INS: begin
                if (i_any) begin
                    n_entry = i_left;
                end else if (r_flag) begin
                    n_entry = i_bus.key;
                end
            end
            CO_SHIFT_REM: begin
                if (i_any || r_flag) begin
                    n_entry = i_right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

    assign o_any   = i_any | r_flag;
    assign o_entry = r_entry;

endmodule

// ===== sv/stq_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_chk
// Port-level checks on the sorted timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_timer_queue_top_assert.svh"

module stq_chk (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_ready,
    input  stq_pkg::t_rsp         i_rsp_data
);
    import stq_pkg::*;

    `STQ_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)
    `STQ_ASSERT_NOW(a_count_max, i_clk, i_rst_n, i_rsp_valid, i_rsp_data.timer_count <= CNT_W'(DEPTH))
    `STQ_ASSERT_NOW(a_head_cnt, i_clk, i_rst_n, i_rsp_valid, i_rsp_data.head_valid == (i_rsp_data.timer_count != '0))
    `STQ_ASSERT_NOW(a_full_cnt, i_clk, i_rst_n, i_rsp_valid && i_rsp_data.status == STAT_FULL, i_rsp_data.timer_count == CNT_W'(DEPTH))
    `STQ_ASSERT_NEXT(a_one_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

endmodule

bind sorted_timer_queue_top stq_chk u_stq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted timer queue. A shadow timer list predicts
// every result; a short table of hand-picked requests runs first, then about
// 850 random requests in insert-heavy, drain-heavy and mixed phases, with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
    import stq_pkg::*;

    // request type the block leaves alone
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [TIME_W-1:0] T_MAX  = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic signed [TIME_W-1:0] T_MIN  = {1'b1, {(TIME_W-1){1'b0}}};
    localparam logic [EL_W-1:0]          EL_MAX = '1;

    localparam int RANDOM_ITEMS = 850;
    localparam int CALM_TAIL    = 100;  // last requests run with no stalls
    localparam int DRAIN_AT     = 400;  // sender waits for all results here
    localparam int HOLD_AT      = 250;  // receiver holds off after this many
    localparam int HOLD_CYCLES  = 120;
    localparam int STUCK_LIMIT  = 2000; // cycles with no transfer at all

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    typedef struct {
        t_req req;
        bit   typed;    // want holds a hand-written result
        t_rsp want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    stq_req_if req_ch ();
    stq_rsp_if rsp_ch ();

    sorted_timer_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Shadow timer list: slot 0 is the head.
    // ------------------------------------------------------------------
    logic signed [TIME_W-1:0] shadow_time [DEPTH];
    logic [ID_W-1:0]          shadow_id   [DEPTH];
    int                       shadow_count = 0;

    t_rsp timer_rsp_q [$];      // expected results, oldest first
    t_row plan [$];             // directed requests
    int   mismatches = 0;
    bit   tail_calm  = 1'b0;    // set by the sender, seen by the receiver

    function automatic bit shadow_put(input logic [ID_W-1:0] id,
                                      input logic signed [TIME_W-1:0] t);
        int pos;
        if (shadow_count >= DEPTH)
            return 1'b0;
        // only a strictly later head is overtaken; past the head, the new
        // entry lands before the first entry that is not less than it
        if (shadow_count == 0 || t < shadow_time[0]) begin
            pos = 0;
        end else begin
            pos = 1;
            while (pos < shadow_count && shadow_time[pos] < t)
                pos++;
        end
        for (int k = shadow_count; k > pos; k--) begin
            shadow_time[k] = shadow_time[k-1];
            shadow_id[k]   = shadow_id[k-1];
        end
        shadow_time[pos] = t;
        shadow_id[pos]   = id;
        shadow_count++;
        return 1'b1;
    endfunction

    function automatic void shadow_drop(input int pos);
        for (int k = pos; k + 1 < shadow_count; k++) begin
            shadow_time[k] = shadow_time[k+1];
            shadow_id[k]   = shadow_id[k+1];
        end
        shadow_count--;
    endfunction

    function automatic t_rsp timer_list_step(input t_req r);
        t_rsp            o;
        logic [ID_W-1:0] popped;
        bit              hit;
        o = '0;
        o.status = STAT_OK;
        case (r.req_type)
            REQ_INSERT: begin
                if (!shadow_put(r.timer_id, r.time_value))
                    o.status = STAT_FULL;
            end
            REQ_REMOVE: begin
                hit = 1'b0;
                for (int k = 0; k < shadow_count && !hit; k++) begin
                    if (shadow_id[k] == r.timer_id) begin
                        shadow_drop(k);
                        hit = 1'b1;
                    end
                end
                if (!hit)
                    o.status = STAT_NOT_FOUND;
            end
            REQ_FIRE: begin
                if (shadow_count == 0) begin
                    o.status = STAT_EMPTY;
                end else begin
                    popped = shadow_id[0];
                    shadow_drop(0);
                    // plain 40-bit wrap, no saturation
                    for (int k = 0; k < shadow_count; k++)
                        shadow_time[k] = shadow_time[k] - {1'b0, r.elapsed};
                    if (r.rearm)
                        void'(shadow_put(popped, r.time_value));
                    o.fired_id = popped;
                end
            end
            default: ;
        endcase
        if (shadow_count > 0) begin
            o.head_valid = 1'b1;
            o.head_id    = shadow_id[0];
            o.head_time  = shadow_time[0];
        end
        o.timer_count = CNT_W'(shadow_count);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_row(input t_req r, input bit typed = 1'b0,
                           input t_rsp want = '0);
        t_row row;
        row.req   = r;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    function automatic t_req random_request(input t_mix mix);
        t_req r;
        int   roll;
        int   ins_w;
        int   rem_w;
        case (mix)
            MIX_FILL:  begin ins_w = 70; rem_w = 10; end
            MIX_DRAIN: begin ins_w = 20; rem_w = 35; end
            default:   begin ins_w = 40; rem_w = 25; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < 3)
            r.req_type = REQ_UNUSED;
        else if (roll < 3 + ins_w)
            r.req_type = REQ_INSERT;
        else if (roll < 3 + ins_w + rem_w)
            r.req_type = REQ_REMOVE;
        else
            r.req_type = REQ_FIRE;

        // removes mostly name a timer that is held; inserts reuse a small
        // pool of ids so duplicates show up
        if (r.req_type == REQ_REMOVE && shadow_count > 0 && $urandom_range(0, 3) != 0)
            r.timer_id = shadow_id[$urandom_range(0, shadow_count - 1)];
        else if ($urandom_range(0, 1) == 1)
            r.timer_id = ID_W'($urandom_range(0, 15));
        else
            r.timer_id = ID_W'($urandom_range(0, 255));

        case ($urandom_range(0, 9))
            0, 1, 2, 3: r.time_value = TIME_W'($urandom_range(0, 64)) - 40'sd32;
            4, 5, 6:    r.time_value = TIME_W'({$urandom, $urandom});
            7: begin
                case ($urandom_range(0, 3))
                    0:       r.time_value = T_MAX;
                    1:       r.time_value = T_MIN;
                    2:       r.time_value = '0;
                    default: r.time_value = '1;
                endcase
            end
            default: begin
                // tie with a held entry
                if (shadow_count > 0)
                    r.time_value = shadow_time[$urandom_range(0, shadow_count - 1)];
                else
                    r.time_value = '0;
            end
        endcase

        case ($urandom_range(0, 9))
            0, 1, 2, 3: r.elapsed = EL_W'($urandom_range(0, 100));
            4, 5:       r.elapsed = '0;
            6, 7, 8:    r.elapsed = EL_W'({$urandom, $urandom});
            default:    r.elapsed = EL_MAX;
        endcase

        r.rearm = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Offer one request and hold it until the transfer; the prediction is
    // made at the transfer edge.
    task automatic offer_request(input t_req r, input bit typed, input t_rsp want);
        t_rsp p;
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        p = timer_list_step(r);
        timer_rsp_q.push_back(typed ? want : p);
    endtask

    task automatic pause_sender(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input longint got,
                                   input longint exp);
        mismatches++;
        $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, exp);
    endtask

    // ------------------------------------------------------------------
    // Result monitor: every transfer on the result channel is checked
    // against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (timer_rsp_q.size() == 0) begin
                report_mismatch("unexpected result, status", got.status, -1);
            end else begin
                want = timer_rsp_q.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.fired_id != want.fired_id)
                    report_mismatch("fired_id", got.fired_id, want.fired_id);
                if (got.head_valid != want.head_valid)
                    report_mismatch("head_valid", got.head_valid, want.head_valid);
                if (got.head_id != want.head_id)
                    report_mismatch("head_id", got.head_id, want.head_id);
                if (got.head_time != want.head_time)
                    report_mismatch("head_time", got.head_time, want.head_time);
                if (got.timer_count != want.timer_count)
                    report_mismatch("timer_count", got.timer_count, want.timer_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts in some windows, none in others, one
    // long hold-off so the single request slot backs up, none at the tail.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        int seen;
        int window;
        bit held;
        bit quiet;
        stall  = 0;
        seen   = 0;
        window = 0;
        held   = 1'b0;
        quiet  = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready)
                seen++;
            if (window == 0) begin
                quiet  = ($urandom_range(0, 2) == 0);
                window = $urandom_range(100, 300);
            end
            window--;
            if (!held && seen >= HOLD_AT) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end else if (!tail_calm && !quiet && $urandom_range(0, 99) < 20) begin
                stall = $urandom_range(1, 14) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no transfer happens on either channel for
    // too long.
    // ------------------------------------------------------------------
    int stuck_cycles = 0;
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender / sequencer
    // ------------------------------------------------------------------
    initial begin
        t_req r;
        t_mix mix;
        int   phase_len;
        int   work_items;
        bit   gapless;
        bit   drained;
        bit   calm;

        i_rst_n      <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;

        // Directed table. Rows with a typed result are the ones that can be
        // read straight off the spec; the rest go through the shadow list.
        // empty queue: fire, remove and the unused code change nothing
        add_row('{REQ_FIRE, 8'h00, '1, 39'd7, 1'b1}, 1'b1,
                '{STAT_EMPTY, 8'h00, 1'b0, 8'h00, 40'sd0, 5'd0});
        add_row('{REQ_REMOVE, 8'h05, '0, '0, 1'b0}, 1'b1,
                '{STAT_NOT_FOUND, 8'h00, 1'b0, 8'h00, 40'sd0, 5'd0});
        add_row('{REQ_UNUSED, 8'hA5, T_MAX, EL_MAX, 1'b1}, 1'b1,
                '{STAT_OK, 8'h00, 1'b0, 8'h00, 40'sd0, 5'd0});
        // time extremes, largest first so the smallest overtakes it
        add_row('{REQ_INSERT, 8'hFF, T_MAX, '0, 1'b0}, 1'b1,
                '{STAT_OK, 8'h00, 1'b1, 8'hFF, T_MAX, 5'd1});
        add_row('{REQ_INSERT, 8'h00, T_MIN, '0, 1'b0}, 1'b1,
                '{STAT_OK, 8'h00, 1'b1, 8'h00, T_MIN, 5'd2});
        // equal times: behind the head, ahead of later equal entries
        add_row('{REQ_INSERT, 8'h11, 40'sd0, '0, 1'b0});
        add_row('{REQ_INSERT, 8'h12, 40'sd0, '0, 1'b0});
        add_row('{REQ_INSERT, 8'h13, T_MIN, '0, 1'b0});
        add_row('{REQ_INSERT, 8'h11, 40'sd5, '0, 1'b0});
        for (int k = 0; k < 10; k++)
            add_row('{REQ_INSERT, ID_W'(8'h40 + k), TIME_W'(k * 7 - 30), '0, 1'b0});
        // sixteen held: insert is refused
        add_row('{REQ_INSERT, 8'h99, 40'sd0, '0, 1'b0}, 1'b1,
                '{STAT_FULL, 8'h00, 1'b1, 8'h00, T_MIN, 5'd16});
        // duplicate id: the one nearer the head goes
        add_row('{REQ_REMOVE, 8'h11, '0, '0, 1'b0});
        add_row('{REQ_REMOVE, 8'h77, '0, '0, 1'b0});
        // largest elapsed wraps the negative entries around
        add_row('{REQ_FIRE, 8'h00, '0, EL_MAX, 1'b0});
        add_row('{REQ_FIRE, 8'h00, '1, 39'd3, 1'b1});
        add_row('{REQ_UNUSED, 8'h5A, '0, '0, 1'b0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            offer_request(plan[i].req, plan[i].typed, plan[i].want);
            if ($urandom_range(0, 2) == 0)
                pause_sender($urandom_range(1, 14));
        end

        // Random phases. Ignored requests do not count as work.
        work_items = 0;
        drained    = 1'b0;
        while (work_items < RANDOM_ITEMS) begin
            mix       = t_mix'($urandom_range(0, 2));
            phase_len = $urandom_range(20, 60);
            gapless   = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < phase_len && work_items < RANDOM_ITEMS; j++) begin
                r = random_request(mix);
                if (r.req_type != REQ_UNUSED)
                    work_items++;
                calm = (RANDOM_ITEMS - work_items < CALM_TAIL);
                if (calm)
                    tail_calm <= 1'b1;
                offer_request(r, 1'b0, '0);
                if (!drained && work_items >= DRAIN_AT) begin
                    // let the block run dry before offering more
                    drained = 1'b1;
                    req_ch.valid <= 1'b0;
                    do @(posedge i_clk); while (timer_rsp_q.size() != 0);
                end else if (!calm && !gapless && $urandom_range(0, 3) == 0) begin
                    pause_sender($urandom_range(1, 14));
                end
            end
        end

        // drain, then let the clock run on quietly to catch stray results
        req_ch.valid <= 1'b0;
        while (timer_rsp_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
